### rtl/core/frsp_pkg.sv
// Shared types, constants and CRC helper for the FIT record stream parser.
// Used by frsp_core and fit_record_stream_parser; depends on nothing.
package frsp_pkg;

    localparam int DefaultMaxFields = 128;
    localparam logic [15:0] DecodeSizeReset = 16'd40;

    localparam int NumValues = 7;

    // Status codes of a file report.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SIGNATURE  = 4'd1;
    localparam logic [3:0] ST_HEADER_CRC = 4'd2;
    localparam logic [3:0] ST_COMPRESSED = 4'd3;
    localparam logic [3:0] ST_UNKNOWN_ID = 4'd4;
    localparam logic [3:0] ST_FIELD_SIZE = 4'd5;
    localparam logic [3:0] ST_LENGTH     = 4'd6;
    localparam logic [3:0] ST_FILE_CRC   = 4'd7;
    localparam logic [3:0] ST_TOO_MANY   = 4'd8;

    // Result kinds.
    localparam logic KIND_POINT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Captured value slots.
    localparam int SLOT_TIME = 0;
    localparam int SLOT_LAT  = 1;
    localparam int SLOT_LON  = 2;
    localparam int SLOT_ALT  = 3;
    localparam int SLOT_TEMP = 4;
    localparam int SLOT_SPD  = 5;
    localparam int SLOT_DIST = 6;

    localparam logic [7:0] FID_TIME = 8'd253;
    localparam logic [7:0] FID_LAT  = 8'd0;
    localparam logic [7:0] FID_LON  = 8'd1;
    localparam logic [7:0] FID_ALT  = 8'd78;
    localparam logic [7:0] FID_TEMP = 8'd13;
    localparam logic [7:0] FID_SPD  = 8'd73;
    localparam logic [7:0] FID_DIST = 8'd5;

    localparam logic [7:0] HDR_SIZE = 8'd14;

    typedef logic [NumValues-1:0][31:0] values_t;

    typedef struct packed {
        logic      kind;
        values_t   values;
        logic [3:0] status;
    } frsp_result_t;

    localparam logic [15:0] NIB_TABLE [16] = '{
        16'h0000, 16'hcc01, 16'hd801, 16'h1400, 16'hf001, 16'h3c00, 16'h2800, 16'he401,
        16'ha001, 16'h6c00, 16'h7800, 16'hb401, 16'h5000, 16'h9c01, 16'h8801, 16'h4400
    };

    localparam logic [7:0] SIG_BYTES [4] = '{8'h2e, 8'h46, 8'h49, 8'h54};

    localparam logic [15:0] KNOWN_GIDS [8] = '{
        16'd0, 16'd18, 16'd19, 16'd20, 16'd21, 16'd23, 16'd34, 16'd49
    };

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        t = (c >> 4) ^ NIB_TABLE[c[3:0]] ^ NIB_TABLE[b[3:0]];
        return (t >> 4) ^ NIB_TABLE[t[3:0]] ^ NIB_TABLE[b[7:4]];
    endfunction

    function automatic logic known_gid(input logic [15:0] gid);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            if (KNOWN_GIDS[i] == gid)
                hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

### rtl/core/frsp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module frsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/frsp_core.sv
// Byte-at-a-time FIT parse state and its next-state logic.
// Depends on frsp_pkg and frsp_ram (definition field table).
module frsp_core #(
    parameter int MAX_FIELDS = frsp_pkg::DefaultMaxFields
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_en,
    input  logic [7:0]            in_byte,
    input  logic                  in_first,
    input  logic                  in_last,
    input  logic [15:0]           decode_size,
    output logic                  res_valid,
    output frsp_pkg::frsp_result_t res
);
    import frsp_pkg::*;

    localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam logic [7:0] MaxF8 = 8'(MAX_FIELDS);

    localparam logic [3:0] PH_HDR        = 4'd0;
    localparam logic [3:0] PH_REC        = 4'd1;
    localparam logic [3:0] PH_DEF_HEAD   = 4'd2;
    localparam logic [3:0] PH_DEF_FIELDS = 4'd3;
    localparam logic [3:0] PH_DEV_COUNT  = 4'd4;
    localparam logic [3:0] PH_DEV_FIELDS = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_VALUES     = 4'd7;
    localparam logic [3:0] PH_TRAIL      = 4'd8;
    localparam logic [3:0] PH_DONE       = 4'd9;

    logic [3:0]  phase_reg, phase_next;
    logic [15:0] bc_reg, bc_next;
    logic [31:0] dr_reg, dr_next;
    logic [15:0] fcrc_reg, fcrc_next;
    logic [15:0] hcrc_reg, hcrc_next;
    logic [7:0]  hlen_reg, hlen_next;
    logic [7:0]  total_reg, total_next;
    logic [15:0] rb_reg, rb_next;
    logic [7:0]  dev_reg, dev_next;
    logic [7:0]  cursor_reg, cursor_next;
    logic [31:0] va_reg, va_next;
    logic [7:0]  gidl_reg, gidl_next;
    values_t     cap_reg, cap_next;
    logic        err_reg, err_next;
    // Current entry of the field table, plus a copy of entry zero.
    logic [7:0]  cur_id_reg, cur_id_next;
    logic [7:0]  cur_size_reg, cur_size_next;
    logic [7:0]  e0_id_reg, e0_id_next;
    logic [7:0]  e0_size_reg, e0_size_next;
    logic [7:0]  def_id_reg, def_id_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   rd_data;
    logic [7:0]    cur_plus1;

    logic          point;
    logic          report;
    logic [3:0]    code;

    assign cur_plus1 = cursor_next + 8'd1;

    frsp_ram #(
        .WIDTH (16),
        .DEPTH (MAX_FIELDS)
    ) u_fields (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({def_id_reg, in_byte}),
        .rd_addr (cur_plus1[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic [7:0]  b;
        logic        in_data;
        logic        do_start;
        logic [7:0]  st_size;
        logic [31:0] va_new;
        logic [7:0]  hl_eff;

        b = in_byte;
        phase_next    = in_first ? PH_HDR : phase_reg;
        bc_next       = in_first ? '0 : bc_reg;
        dr_next       = in_first ? '0 : dr_reg;
        fcrc_next     = in_first ? '0 : fcrc_reg;
        hcrc_next     = in_first ? '0 : hcrc_reg;
        hlen_next     = in_first ? '0 : hlen_reg;
        total_next    = in_first ? '0 : total_reg;
        rb_next       = in_first ? '0 : rb_reg;
        dev_next      = in_first ? '0 : dev_reg;
        cursor_next   = in_first ? '0 : cursor_reg;
        va_next       = in_first ? '0 : va_reg;
        gidl_next     = in_first ? '0 : gidl_reg;
        cap_next      = in_first ? '0 : cap_reg;
        err_next      = in_first ? 1'b0 : err_reg;
        cur_id_next   = cur_id_reg;
        cur_size_next = cur_size_reg;
        e0_id_next    = e0_id_reg;
        e0_size_next  = e0_size_reg;
        def_id_next   = def_id_reg;
        wr_en   = 1'b0;
        wr_addr = cursor_next[AW-1:0];
        point   = 1'b0;
        report  = 1'b0;
        code    = ST_OK;
        in_data  = 1'b0;
        do_start = 1'b0;
        st_size  = '0;
        va_new   = '0;
        hl_eff   = '0;

        if (!in_en)
        begin
            phase_next = phase_reg; bc_next = bc_reg; dr_next = dr_reg;
            fcrc_next = fcrc_reg; hcrc_next = hcrc_reg; hlen_next = hlen_reg;
            total_next = total_reg; rb_next = rb_reg; dev_next = dev_reg;
            cursor_next = cursor_reg; va_next = va_reg; gidl_next = gidl_reg;
            cap_next = cap_reg; err_next = err_reg;
            wr_addr = cursor_reg[AW-1:0];
        end
        else if (!err_next && phase_next != PH_DONE)
        begin
            fcrc_next = crc_step(fcrc_next, b);
            in_data = (phase_next != PH_HDR) && (phase_next != PH_TRAIL);
            if (in_data)
                dr_next = dr_next - 32'd1;

            unique case (phase_next)
                PH_HDR:
                begin
                    if (bc_next == 16'd0)
                        hlen_next = b;
                    hl_eff = hlen_next;
                    if (bc_next < {8'd0, hl_eff} && bc_next < {8'd0, HDR_SIZE})
                        hcrc_next = crc_step(hcrc_next, b);
                    if (bc_next >= 16'd4 && bc_next <= 16'd7)
                    begin
                        unique case (bc_next[1:0])
                            2'd0: dr_next[7:0]   = dr_next[7:0]   | b;
                            2'd1: dr_next[15:8]  = dr_next[15:8]  | b;
                            2'd2: dr_next[23:16] = dr_next[23:16] | b;
                            default: dr_next[31:24] = dr_next[31:24] | b;
                        endcase
                    end
                    if (bc_next >= 16'd8 && bc_next <= 16'd11
                        && b != SIG_BYTES[bc_next[1:0]])
                    begin
                        report = 1'b1;
                        code   = ST_SIGNATURE;
                    end
                    else
                    begin
                        bc_next = bc_next + 16'd1;
                        if (bc_next == {8'd0, HDR_SIZE})
                        begin
                            if (hcrc_next != 16'd0)
                            begin
                                report = 1'b1;
                                code   = ST_HEADER_CRC;
                            end
                            else
                            begin
                                bc_next = '0;
                                phase_next = (dr_next != 32'd0) ? PH_REC : PH_TRAIL;
                            end
                        end
                    end
                end
                PH_REC:
                begin
                    if (b[7])
                    begin
                        report = 1'b1;
                        code   = ST_COMPRESSED;
                    end
                    else if (b[6])
                    begin
                        va_next    = {26'd0, b[5], 5'd0};
                        rb_next    = '0;
                        bc_next    = 16'd1;
                        phase_next = PH_DEF_HEAD;
                    end
                    else if (rb_next == decode_size)
                    begin
                        cap_next      = '0;
                        cursor_next   = '0;
                        cur_id_next   = e0_id_reg;
                        cur_size_next = e0_size_reg;
                        st_size       = e0_size_reg;
                        do_start      = 1'b1;
                    end
                    else
                    begin
                        bc_next = '0;
                        if (rb_next != 16'd0)
                            phase_next = PH_SKIP;
                    end
                end
                PH_DEF_HEAD:
                begin
                    if (bc_next == 16'd3)
                        gidl_next = b;
                    if (bc_next == 16'd4 && !known_gid({b, gidl_next}))
                    begin
                        report = 1'b1;
                        code   = ST_UNKNOWN_ID;
                    end
                    else if (bc_next == 16'd5)
                    begin
                        if (b > MaxF8)
                        begin
                            report = 1'b1;
                            code   = ST_TOO_MANY;
                        end
                        else
                        begin
                            total_next  = b;
                            cursor_next = '0;
                            bc_next     = '0;
                            if (b == 8'd0)
                                phase_next = va_next[5] ? PH_DEV_COUNT : PH_REC;
                            else
                                phase_next = PH_DEF_FIELDS;
                        end
                    end
                    else
                        bc_next = bc_next + 16'd1;
                end
                PH_DEF_FIELDS:
                begin
                    if (bc_next == 16'd0)
                        def_id_next = b;
                    if (bc_next == 16'd1)
                    begin
                        wr_en   = 1'b1;
                        rb_next = rb_next + {8'd0, b};
                        if (cursor_next == 8'd0)
                        begin
                            e0_id_next   = def_id_reg;
                            e0_size_next = b;
                        end
                    end
                    wr_addr = cursor_next[AW-1:0];
                    bc_next = bc_next + 16'd1;
                    if (bc_next >= 16'd3)
                    begin
                        bc_next     = '0;
                        cursor_next = cursor_next + 8'd1;
                        if (cursor_next >= total_next)
                            phase_next = va_next[5] ? PH_DEV_COUNT : PH_REC;
                    end
                end
                PH_DEV_COUNT:
                begin
                    dev_next   = b;
                    bc_next    = '0;
                    phase_next = (b != 8'd0) ? PH_DEV_FIELDS : PH_REC;
                end
                PH_DEV_FIELDS:
                begin
                    bc_next = bc_next + 16'd1;
                    if (bc_next >= 16'd3)
                    begin
                        bc_next  = '0;
                        dev_next = dev_next - 8'd1;
                        if (dev_next == 8'd0)
                            phase_next = PH_REC;
                    end
                end
                PH_SKIP:
                begin
                    bc_next = bc_next + 16'd1;
                    if (bc_next >= rb_next)
                    begin
                        bc_next    = '0;
                        phase_next = PH_REC;
                    end
                end
                PH_VALUES:
                begin
                    va_new = va_next | ({24'd0, b} << {bc_next[1:0], 3'd0});
                    va_next = va_new;
                    bc_next = bc_next + 16'd1;
                    if (cursor_next < MaxF8 && bc_next >= {8'd0, cur_size_reg})
                    begin
                        unique case (cur_id_reg)
                            FID_TIME: cap_next[SLOT_TIME] = va_new;
                            FID_LAT:  cap_next[SLOT_LAT]  = va_new;
                            FID_LON:  cap_next[SLOT_LON]  = va_new;
                            FID_ALT:  cap_next[SLOT_ALT]  = va_new;
                            FID_TEMP: cap_next[SLOT_TEMP] = va_new;
                            FID_SPD:  cap_next[SLOT_SPD]  = va_new;
                            FID_DIST: cap_next[SLOT_DIST] = va_new;
                            default: ;
                        endcase
                        cursor_next   = cursor_next + 8'd1;
                        cur_id_next   = rd_data[15:8];
                        cur_size_next = rd_data[7:0];
                        st_size       = rd_data[7:0];
                        do_start      = 1'b1;
                    end
                end
                default: ;
            endcase

            if (do_start)
            begin
                bc_next = '0;
                va_next = '0;
                if (cursor_next >= total_next || cursor_next >= MaxF8)
                begin
                    phase_next = PH_REC;
                    point      = 1'b1;
                end
                else if (st_size != 8'd1 && st_size != 8'd2 && st_size != 8'd4)
                begin
                    report = 1'b1;
                    code   = ST_FIELD_SIZE;
                end
                else
                    phase_next = PH_VALUES;
            end

            if (report)
            begin
                err_next = 1'b1;
                point    = 1'b0;
            end
            else
            begin
                if (in_data && dr_next == 32'd0)
                begin
                    if (phase_next == PH_REC)
                        phase_next = PH_TRAIL;
                    else
                    begin
                        report   = 1'b1;
                        code     = ST_LENGTH;
                        err_next = 1'b1;
                        point    = 1'b0;
                    end
                end
                if (!report && in_last)
                begin
                    report = 1'b1;
                    point  = 1'b0;
                    if (phase_next != PH_TRAIL)
                        code = ST_LENGTH;
                    else if (fcrc_next != 16'd0)
                        code = ST_FILE_CRC;
                    else
                        code = ST_OK;
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_comb
    begin
        res_valid  = report || point;
        res.kind   = report ? KIND_STATUS : KIND_POINT;
        res.values = report ? '0 : cap_next;
        res.status = report ? code : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HDR;
            bc_reg       <= '0;
            dr_reg       <= '0;
            fcrc_reg     <= '0;
            hcrc_reg     <= '0;
            hlen_reg     <= '0;
            total_reg    <= '0;
            rb_reg       <= '0;
            dev_reg      <= '0;
            cursor_reg   <= '0;
            va_reg       <= '0;
            gidl_reg     <= '0;
            cap_reg      <= '0;
            err_reg      <= 1'b0;
            cur_id_reg   <= '0;
            cur_size_reg <= '0;
            e0_id_reg    <= '0;
            e0_size_reg  <= '0;
            def_id_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            bc_reg       <= bc_next;
            dr_reg       <= dr_next;
            fcrc_reg     <= fcrc_next;
            hcrc_reg     <= hcrc_next;
            hlen_reg     <= hlen_next;
            total_reg    <= total_next;
            rb_reg       <= rb_next;
            dev_reg      <= dev_next;
            cursor_reg   <= cursor_next;
            va_reg       <= va_next;
            gidl_reg     <= gidl_next;
            cap_reg      <= cap_next;
            err_reg      <= err_next;
            cur_id_reg   <= cur_id_next;
            cur_size_reg <= cur_size_next;
            e0_id_reg    <= e0_id_next;
            e0_size_reg  <= e0_size_next;
            def_id_reg   <= def_id_next;
        end
    end

endmodule

### rtl/core/fit_record_stream_parser.sv
// Top level of the FIT record stream parser: stream ports, size register,
// result register with skid stage. Depends on frsp_pkg and frsp_core.
//
//  channel   | dir | carries
//  s_axis    | in  | one file byte per beat, first-byte flag, last-byte mark
//  m_axis    | out | data point or file status report per beat
//  cfg       | in  | decode record size write
//
// Every byte is parsed in the cycle it is accepted; a byte can be taken every cycle
// while the skid stage is empty. Each result is registered in the output register, or
// in the skid stage when the output register is still waiting. The output register and
// skid stage hold up to two results; s_axis_tready drops only while the skid stage is full.
// Reset clears all parse state at once; the field table needs no clearing pass.
module fit_record_stream_parser #(
    parameter int MAX_FIELDS = frsp_pkg::DefaultMaxFields
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // data_byte
    input  logic         s_axis_tuser,  // first_byte
    input  logic         s_axis_tlast,  // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // timestamp, latitude, longitude, altitude_raw, temperature_raw,
    // speed_raw, distance_raw, status, zero fill
    output logic [231:0] m_axis_tdata,
    output logic         m_axis_tuser,  // kind
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);
    import frsp_pkg::*;

    logic [15:0]  size_reg;
    logic         accept;
    logic         res_valid;
    frsp_result_t res;
    frsp_result_t out_reg, skid_reg;
    logic         out_v_reg, skid_v_reg;
    logic         pop;

    assign s_axis_tready = !skid_v_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = out_v_reg && m_axis_tready;

    frsp_core #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_en       (accept),
        .in_byte     (s_axis_tdata),
        .in_first    (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .decode_size (size_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= DecodeSizeReset;
        else if (cfg_wr_en)
            size_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pop)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_v_reg || pop)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (pop)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (res_valid)
        begin
            if (!out_v_reg || pop)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {4'd0, out_reg.status, out_reg.values};

    // The skid stage is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid stage holds a beat while output register is empty");

    a_status_zero_values: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.kind == KIND_STATUS) |-> out_reg.values == '0)
        else $error("status report carries nonzero values");

    a_point_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_reg.kind == KIND_POINT) |-> out_reg.status == ST_OK)
        else $error("data point carries nonzero status");

    a_no_result_without_byte: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> !res_valid)
        else $error("result produced without an accepted byte");

endmodule

### bench/fit_record_stream_parser_test.sv
// Self-checking bench for fit_record_stream_parser: directed byte table, then random FIT files.
// Depends on frsp_pkg and the parser RTL; a built-in parser model predicts each beat of an untyped byte.
module fit_record_stream_parser_test;
    import frsp_pkg::*;

    localparam int PR_NONE = -1;
    localparam int PR_POINT = 16;
    localparam int MAXF = 128;

    typedef enum int {
        P_HDR, P_REC, P_DEF_HEAD, P_DEF_FIELDS, P_DEV_COUNT, P_DEV_FIELDS,
        P_SKIP, P_VALUES, P_TRAIL, P_DONE
    } phase_e;

    typedef struct {
        logic        kind;
        logic [31:0] vals [7];
        logic [3:0]  status;
    } fit_result_t;

    typedef struct {
        logic [7:0] b;
        logic       f;
        logic       l;
        logic       typed;
        logic [3:0] st;
    } dir_row_t;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready, s_axis_tuser, s_axis_tlast;
    logic [7:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready, m_axis_tuser;
    logic [231:0] m_axis_tdata;
    logic cfg_wr_en;
    logic [15:0] cfg_wr_data;

    fit_record_stream_parser dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // Parser model state.
    phase_e      ph;
    logic [15:0] bcnt, rec_bytes, decode_size;
    logic [31:0] data_left, vacc;
    logic [15:0] file_crc, hdr_crc;
    logic [7:0]  hdr_len, ftot, dev_left, fcur, gid_lo;
    logic [7:0]  fid [MAXF];
    logic [7:0]  fsz [MAXF];
    logic [31:0] cap [7];
    logic        err_latched;

    fit_result_t expected_beats [$];
    int errors = 0, points_seen = 0, status_seen = 0, bytes_sent = 0;
    int src_idle = 0, sink_stall = 0, hold_cycles = 0;
    logic drv_typed;
    logic [3:0] drv_st;

    function automatic logic [15:0] nib_crc(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] t;
        t = (c >> 4) ^ NIB_TABLE[c[3:0]] ^ NIB_TABLE[b[3:0]];
        t = (t >> 4) ^ NIB_TABLE[t[3:0]] ^ NIB_TABLE[b[7:4]];
        return t;
    endfunction

    function automatic void clear_parser();
        ph = P_HDR; bcnt = 0; data_left = 0; file_crc = 0; hdr_crc = 0; hdr_len = 0;
        ftot = 0; rec_bytes = 0; dev_left = 0; fcur = 0; vacc = 0; gid_lo = 0;
        err_latched = 0;
        for (int i = 0; i < MAXF; i++)
        begin
            fid[i] = 0;
            fsz[i] = 0;
        end
        for (int i = 0; i < 7; i++)
            cap[i] = 0;
    endfunction

    function automatic int next_value();
        logic [7:0] s;
        bcnt = 0;
        vacc = 0;
        if (fcur >= ftot || fcur >= MAXF)
        begin
            ph = P_REC;
            return PR_POINT;
        end
        s = fsz[fcur];
        if (s != 1 && s != 2 && s != 4)
            return ST_FIELD_SIZE;
        ph = P_VALUES;
        return PR_NONE;
    endfunction

    function automatic void capture(input logic [7:0] id, input logic [31:0] v);
        case (id)
            FID_TIME: cap[SLOT_TIME] = v;
            FID_LAT:  cap[SLOT_LAT]  = v;
            FID_LON:  cap[SLOT_LON]  = v;
            FID_ALT:  cap[SLOT_ALT]  = v;
            FID_TEMP: cap[SLOT_TEMP] = v;
            FID_SPD:  cap[SLOT_SPD]  = v;
            FID_DIST: cap[SLOT_DIST] = v;
            default: ;
        endcase
    endfunction

    function automatic int parse_one(input logic [7:0] b);
        logic [15:0] gid;
        logic hit;
        case (ph)
            P_HDR:
            begin
                if (bcnt == 0)
                    hdr_len = b;
                if (bcnt < hdr_len && bcnt < 14)
                    hdr_crc = nib_crc(hdr_crc, b);
                if (bcnt >= 4 && bcnt <= 7)
                    data_left |= 32'(b) << (8 * (bcnt - 4));
                if (bcnt >= 8 && bcnt <= 11 && b != SIG_BYTES[bcnt - 8])
                    return ST_SIGNATURE;
                bcnt++;
                if (bcnt == 14)
                begin
                    if (hdr_crc != 0)
                        return ST_HEADER_CRC;
                    bcnt = 0;
                    ph = (data_left != 0) ? P_REC : P_TRAIL;
                end
                return PR_NONE;
            end
            P_REC:
            begin
                if (b[7])
                    return ST_COMPRESSED;
                if (b[6])
                begin
                    vacc = {26'd0, b[5], 5'd0};
                    rec_bytes = 0;
                    bcnt = 1;
                    ph = P_DEF_HEAD;
                    return PR_NONE;
                end
                if (rec_bytes == decode_size)
                begin
                    for (int i = 0; i < 7; i++)
                        cap[i] = 0;
                    fcur = 0;
                    return next_value();
                end
                bcnt = 0;
                if (rec_bytes != 0)
                    ph = P_SKIP;
                return PR_NONE;
            end
            P_DEF_HEAD:
            begin
                if (bcnt == 3)
                    gid_lo = b;
                if (bcnt == 4)
                begin
                    gid = {b, gid_lo};
                    hit = 0;
                    for (int i = 0; i < 8; i++)
                        if (KNOWN_GIDS[i] == gid)
                            hit = 1;
                    if (!hit)
                        return ST_UNKNOWN_ID;
                end
                if (bcnt == 5)
                begin
                    if (b > MAXF)
                        return ST_TOO_MANY;
                    ftot = b;
                    fcur = 0;
                    bcnt = 0;
                    if (b == 0)
                    begin
                        bcnt = 0;
                        ph = vacc[5] ? P_DEV_COUNT : P_REC;
                    end
                    else
                        ph = P_DEF_FIELDS;
                    return PR_NONE;
                end
                bcnt++;
                return PR_NONE;
            end
            P_DEF_FIELDS:
            begin
                if (fcur < MAXF)
                begin
                    if (bcnt == 0)
                        fid[fcur] = b;
                    if (bcnt == 1)
                    begin
                        fsz[fcur] = b;
                        rec_bytes = rec_bytes + 16'(b);
                    end
                end
                bcnt++;
                if (bcnt >= 3)
                begin
                    bcnt = 0;
                    fcur++;
                    if (fcur >= ftot)
                        ph = vacc[5] ? P_DEV_COUNT : P_REC;
                end
                return PR_NONE;
            end
            P_DEV_COUNT:
            begin
                dev_left = b;
                bcnt = 0;
                ph = (b != 0) ? P_DEV_FIELDS : P_REC;
                return PR_NONE;
            end
            P_DEV_FIELDS:
            begin
                bcnt++;
                if (bcnt >= 3)
                begin
                    bcnt = 0;
                    dev_left--;
                    if (dev_left == 0)
                        ph = P_REC;
                end
                return PR_NONE;
            end
            P_SKIP:
            begin
                bcnt++;
                if (bcnt >= rec_bytes)
                begin
                    bcnt = 0;
                    ph = P_REC;
                end
                return PR_NONE;
            end
            P_VALUES:
            begin
                vacc |= 32'(b) << (8 * bcnt[1:0]);
                bcnt++;
                if (fcur < MAXF && bcnt >= fsz[fcur])
                begin
                    capture(fid[fcur], vacc);
                    fcur++;
                    return next_value();
                end
                return PR_NONE;
            end
            default: return PR_NONE;
        endcase
    endfunction

    function automatic fit_result_t status_beat(input logic [3:0] st);
        fit_result_t r;
        r.kind = KIND_STATUS;
        for (int i = 0; i < 7; i++)
            r.vals[i] = 0;
        r.status = st;
        return r;
    endfunction

    // Advances the model by one accepted byte; returns 1 when the byte yields a beat.
    function automatic logic parse_byte_beat(input logic [7:0] b, input logic f,
                                             input logic l, output fit_result_t r);
        logic in_data;
        int pr;
        if (f)
            clear_parser();
        if (err_latched || ph == P_DONE)
            return 0;
        file_crc = nib_crc(file_crc, b);
        in_data = (ph != P_HDR && ph != P_TRAIL);
        if (in_data)
            data_left--;
        pr = parse_one(b);
        if (pr != PR_NONE && pr != PR_POINT)
        begin
            r = status_beat(4'(pr));
            err_latched = 1;
            return 1;
        end
        if (in_data && data_left == 0)
        begin
            if (ph == P_REC)
                ph = P_TRAIL;
            else
            begin
                r = status_beat(ST_LENGTH);
                err_latched = 1;
                return 1;
            end
        end
        if (l)
        begin
            r = status_beat(ph != P_TRAIL ? ST_LENGTH : (file_crc != 0 ? ST_FILE_CRC : ST_OK));
            ph = P_DONE;
            return 1;
        end
        if (pr == PR_POINT)
        begin
            r.kind = KIND_POINT;
            for (int i = 0; i < 7; i++)
                r.vals[i] = cap[i];
            r.status = ST_OK;
            return 1;
        end
        return 0;
    endfunction

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Scoreboard and model update, all on the rising edge.
    always @(posedge clk)
    begin
        fit_result_t r, e;
        logic got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_beats.pop_front();
                    if (m_axis_tuser != e.kind)
                    begin
                        $error("kind: expected %0d actual %0d", e.kind, m_axis_tuser);
                        errors++;
                    end
                    for (int i = 0; i < 7; i++)
                        if (m_axis_tdata[32*i +: 32] != e.vals[i])
                        begin
                            $error("value slot %0d: expected %h actual %h", i, e.vals[i],
                                   m_axis_tdata[32*i +: 32]);
                            errors++;
                        end
                    if (m_axis_tdata[227:224] != e.status)
                    begin
                        $error("status: expected %0d actual %0d", e.status,
                               m_axis_tdata[227:224]);
                        errors++;
                    end
                    if (m_axis_tdata[231:228] != 0)
                    begin
                        $error("fill: expected 0 actual %h", m_axis_tdata[231:228]);
                        errors++;
                    end
                    if (e.kind == KIND_POINT)
                        points_seen++;
                    else
                        status_seen++;
                end
            end
            if (cfg_wr_en)
                decode_size = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_sent++;
                got = parse_byte_beat(s_axis_tdata, s_axis_tuser, s_axis_tlast, r);
                if (drv_typed)
                    expected_beats.push_back(status_beat(drv_st));
                else if (got)
                    expected_beats.push_back(r);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready = 0;
                hold_cycles--;
            end
            else
                m_axis_tready = ($urandom_range(0, 99) >= sink_stall);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
                             input logic typed = 0, input logic [3:0] st = ST_OK);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < src_idle)
                s_axis_tvalid = 0;
            else
                break;
        end
        s_axis_tvalid = 1;
        s_axis_tdata = b;
        s_axis_tuser = f;
        s_axis_tlast = l;
        drv_typed = typed;
        drv_st = st;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic settle();
        @(negedge clk);
        s_axis_tvalid = 0;
        drv_typed = 0;
        while (expected_beats.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_size(input logic [15:0] v);
        settle();
        cfg_wr_en = 1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 0;
    endtask

    function automatic logic [7:0] rnd_value_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds one FIT file, mostly well formed; if tsize <= 60, some decodable definitions sum to tsize.
    task automatic make_file(input int tsize, output logic [7:0] fileb [$]);
        logic [7:0] dat [$];
        logic [7:0] hdr [$];
        logic [7:0] ids [$];
        logic [7:0] szs [$];
        logic [7:0] fids [7] = '{FID_TIME, FID_LAT, FID_LON, FID_ALT, FID_TEMP,
                                 FID_SPD, FID_DIST};
        logic [15:0] c, gid;
        logic [31:0] dlen;
        int ndef, rem, s, nrec, sum, ndev, nf;
        logic dev, dec, stop;
        stop = 0;
        ndef = $urandom_range(0, 3);
        for (int d = 0; d < ndef && !stop; d++)
        begin
            dec = (tsize <= 60) && ($urandom_range(0, 2) != 0);
            dev = ($urandom_range(0, 3) == 0);
            dat.push_back(8'h40 | (dev ? 8'h20 : 8'h00) | 8'($urandom_range(0, 31)));
            dat.push_back(8'($urandom_range(0, 255)));
            dat.push_back(8'($urandom_range(0, 1)));
            gid = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                : KNOWN_GIDS[$urandom_range(0, 7)];
            dat.push_back(gid[7:0]);
            dat.push_back(gid[15:8]);
            ids.delete();
            szs.delete();
            if (dec)
            begin
                rem = tsize;
                while (rem > 0)
                begin
                    s = 4 >> $urandom_range(0, 2);
                    if (s > rem)
                        s = 1;
                    rem -= s;
                    szs.push_back(8'(s));
                end
            end
            else
            begin
                nf = $urandom_range(0, 5);
                for (int i = 0; i < nf; i++)
                    szs.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 7))
                                                              : 8'(4 >> $urandom_range(0, 2)));
            end
            if ($urandom_range(0, 29) == 0)
            begin
                dat.push_back(8'($urandom_range(129, 255)));
                stop = 1;
            end
            else
            begin
                dat.push_back(8'(szs.size()));
                sum = 0;
                foreach (szs[i])
                begin
                    ids.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                              : fids[$urandom_range(0, 6)]);
                    dat.push_back(ids[i]);
                    dat.push_back(szs[i]);
                    dat.push_back(8'($urandom_range(0, 255)));
                    sum += szs[i];
                end
                if (dev)
                begin
                    ndev = $urandom_range(0, 2);
                    dat.push_back(8'(ndev));
                    repeat (3 * ndev) dat.push_back(8'($urandom_range(0, 255)));
                end
                nrec = $urandom_range(0, 4);
                for (int k = 0; k < nrec; k++)
                begin
                    dat.push_back(($urandom_range(0, 39) == 0) ? 8'($urandom_range(128, 255))
                                                               : 8'($urandom_range(0, 63)));
                    dat[$] = dat[$][7] ? dat[$] : (dat[$] & 8'hbf);
                    repeat (sum) dat.push_back(rnd_value_byte());
                end
            end
        end
        dlen = dat.size();
        if ($urandom_range(0, 14) == 0)
            dlen = dlen + $urandom_range(1, 3) - 2;
        hdr.push_back(($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 13)) : HDR_SIZE);
        hdr.push_back(8'h10);
        hdr.push_back(8'($urandom_range(0, 255)));
        hdr.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
            hdr.push_back(dlen[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            hdr.push_back(SIG_BYTES[i]);
        if ($urandom_range(0, 29) == 0)
            hdr[8 + $urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        c = 0;
        foreach (hdr[i])
            c = nib_crc(c, hdr[i]);
        hdr.push_back(c[7:0]);
        hdr.push_back(c[15:8]);
        fileb = {hdr, dat};
        c = 0;
        foreach (fileb[i])
            c = nib_crc(c, fileb[i]);
        fileb.push_back(c[7:0]);
        fileb.push_back(c[15:8]);
        // Occasional damage: a flipped bit somewhere, or a cut-off file.
        if ($urandom_range(0, 14) == 0)
            fileb[$urandom_range(0, fileb.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 14) == 0)
            while (fileb.size() > 1 && $urandom_range(0, 3) != 0)
                void'(fileb.pop_back());
    endtask

    dir_row_t dir_tab [25] = '{
        // Bad signature at the second magic byte.
        '{8'd14, 1, 0, 0, ST_OK}, '{8'h10, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK},
        '{8'h08, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK},
        '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h2e, 0, 0, 0, ST_OK},
        '{8'h00, 0, 0, 1, ST_SIGNATURE},
        // One-byte file: header never completes.
        '{8'hff, 1, 1, 1, ST_LENGTH},
        // Zero header length skips the header CRC; empty data area, bad file CRC.
        '{8'h00, 1, 0, 0, ST_OK}, '{8'h20, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK},
        '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK},
        '{8'h00, 0, 0, 0, ST_OK}, '{8'h00, 0, 0, 0, ST_OK}, '{8'h2e, 0, 0, 0, ST_OK},
        '{8'h46, 0, 0, 0, ST_OK}, '{8'h49, 0, 0, 0, ST_OK}, '{8'h54, 0, 0, 0, ST_OK},
        '{8'hff, 0, 0, 0, ST_OK}, '{8'hff, 0, 1, 0, ST_OK}
    };

    initial
    begin
        logic [7:0] fileb [$];
        int tsize, phase_bytes, nphase;
        int idle_src [4] = '{0, 50, 0, 25};
        int idle_snk [4] = '{0, 0, 50, 25};
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tuser = 0;
        s_axis_tlast = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        drv_typed = 0;
        drv_st = ST_OK;
        decode_size = DecodeSizeReset;
        clear_parser();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        foreach (dir_tab[i])
            send_byte(dir_tab[i].b, dir_tab[i].f, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].st);

        nphase = 0;
        while (bytes_sent < 800 && nphase < 40)
        begin
            case (nphase)
                0: tsize = 0;
                1: tsize = 65535;
                2: tsize = 40;
                default: tsize = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(1, 30);
            endcase
            write_size(16'(tsize));
            src_idle = idle_src[nphase % 4];
            sink_stall = idle_snk[nphase % 4];
            // One phase holds the receiver off long enough to back up the input.
            if (nphase == 3)
                hold_cycles = 600;
            phase_bytes = 0;
            while (phase_bytes < 120)
            begin
                make_file(tsize, fileb);
                foreach (fileb[i])
                    send_byte(fileb[i], i == 0, i == fileb.size() - 1);
                phase_bytes += fileb.size();
                // Stray bytes after the report are ignored by the parser.
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 0,
                                                            $urandom_range(0, 1));
            end
            nphase++;
        end
        settle();
        repeat (10) @(negedge clk);
        $display("Covered %0d phases of decode size and idling, %0d bytes in total.",
                 nphase, bytes_sent);
        $display("Checked %0d data points and %0d status reports.", points_seen, status_seen);
        if (errors == 0 && expected_beats.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
rtl/core/frsp_pkg.sv
rtl/core/frsp_ram.sv
rtl/core/frsp_core.sv
rtl/core/fit_record_stream_parser.sv
bench/fit_record_stream_parser_test.sv
